// ===== hdl/bcc_pkg.sv =====
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and fixed field widths for the block range letter counter.
// ----------------------------------------------------------------------------
package bcc_pkg;

  // fixed widths of the item fields
  localparam int INDEX_W  = 12;
  localparam int LETTER_W = 5;
  localparam int COUNT_W  = 13;

  // item operation codes
  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  // top level control states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD_READ,
    S_UPD_DEC,
    S_UPD_INC,
    S_UPD_WRITE,
    S_WALK,
    S_DONE
  } state_t;

  // range walker requests and status toward the controller
  typedef struct packed {
    logic letter_rd;
    logic count_rd;
    logic done;
  } walk_t;

endpackage

// ===== hdl/block_range_char_count.sv =====
// ----------------------------------------------------------------------------
// block_range_char_count
// Letter string with per-block letter counts; updates one position and
// counts one letter over an inclusive index range.
// ----------------------------------------------------------------------------
// After reset the block clears both memories and takes no item until the
// clear pass ends. An update reads the old letter, reads its block count,
// writes the decrement and the new letter, then reads and writes back the
// new letter's count. A query makes one memory read per position in the
// partial blocks at either end and one per whole block, so at most
// 2*(BLK_SIZE-1) + STRING_LENGTH/BLK_SIZE - 2 reads; each memory has a
// single read port. An empty range or a letter outside the alphabet
// answers 0. Updates go on while an earlier query result waits on the
// output.
// ----------------------------------------------------------------------------
module block_range_char_count #(
  parameter int STRING_LENGTH = 4096,
  parameter int BLK_SIZE      = 64,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           opcode,
  input  logic [bcc_pkg::INDEX_W-1:0]    first_index,
  input  logic [bcc_pkg::INDEX_W-1:0]    last_index,
  input  logic [bcc_pkg::LETTER_W-1:0]   letter,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bcc_pkg::COUNT_W-1:0]    count
);

  localparam int PW        = $clog2(STRING_LENGTH);
  localparam int BW        = $clog2(BLK_SIZE);
  localparam int AW        = $clog2(ALPHABET_SIZE);
  localparam int NB        = (STRING_LENGTH + BLK_SIZE - 1) / BLK_SIZE;
  localparam int CDEPTH    = NB * (2 ** AW);
  localparam int CA_W      = $clog2(CDEPTH);
  localparam int CW        = $clog2(BLK_SIZE + 1);
  localparam int TW        = $clog2(STRING_LENGTH + 1);
  localparam int CLR_DEPTH = (STRING_LENGTH > CDEPTH) ? STRING_LENGTH : CDEPTH;
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  bcc_pkg::state_t              state;
  bcc_pkg::state_t              state_next;
  logic [CLR_W-1:0]             clr_idx;
  logic [PW-1:0]                pos;
  logic [bcc_pkg::LETTER_W-1:0] code;
  logic [CA_W-1:0]              old_addr;
  logic                         res_zero;

  logic [31:0]                  first32;
  logic [31:0]                  hi32;
  logic                         in_xfer;
  logic                         upd_ok;
  logic                         q_empty;
  logic                         walk_start;
  logic [CA_W-1:0]              blk_base;
  logic [31:0]                  clr_blk;
  logic [31:0]                  clr_rem;
  logic [31:0]                  clr_span;

  logic                         lw_en;
  logic [PW-1:0]                lw_addr;
  logic [bcc_pkg::LETTER_W-1:0] lw_data;
  logic [PW-1:0]                lr_addr;
  logic [bcc_pkg::LETTER_W-1:0] lr_data;
  logic                         cw_en;
  logic [CA_W-1:0]              cw_addr;
  logic [CW-1:0]                cw_data;
  logic [CA_W-1:0]              cr_addr;
  logic [CW-1:0]                cr_data;

  bcc_pkg::walk_t               walk;
  logic [PW-1:0]                walk_laddr;
  logic [CA_W-1:0]              walk_caddr;
  logic [TW-1:0]                walk_total;

  // input decode: clip the range and flag items that do nothing
  always_comb begin
    in_ready   = state == bcc_pkg::S_IDLE;
    in_xfer    = in_valid && in_ready;
    first32    = 32'(first_index);
    hi32       = (32'(last_index) > 32'(STRING_LENGTH - 1)) ?
                 32'(STRING_LENGTH - 1) : 32'(last_index);
    upd_ok     = (first32 < 32'(STRING_LENGTH)) && (32'(letter) < 32'(ALPHABET_SIZE));
    q_empty    = (32'(letter) >= 32'(ALPHABET_SIZE)) || (first32 > hi32);
    walk_start = in_xfer && (opcode == bcc_pkg::OP_QUERY) && !q_empty;
    blk_base   = CA_W'((32'(pos) >> BW) << AW);
  end

  // reset value of the count entry under the clear pointer
  always_comb begin
    clr_blk  = 32'(clr_idx) >> AW;
    clr_rem  = 32'(STRING_LENGTH) - (clr_blk << BW);
    clr_span = (clr_rem > 32'(BLK_SIZE)) ? 32'(BLK_SIZE) : clr_rem;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bcc_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory port control
  always_comb begin
    state_next = state;
    lw_en      = 1'b0;
    lw_addr    = pos;
    lw_data    = code;
    lr_addr    = walk_laddr;
    cw_en      = 1'b0;
    cw_addr    = old_addr;
    cw_data    = cr_data - CW'(1);
    cr_addr    = walk_caddr;
    case (state)
      bcc_pkg::S_CLEAR: begin
        lw_en   = 32'(clr_idx) < 32'(STRING_LENGTH);
        lw_addr = clr_idx[PW-1:0];
        lw_data = '0;
        cw_en   = 32'(clr_idx) < 32'(CDEPTH);
        cw_addr = clr_idx[CA_W-1:0];
        cw_data = (clr_idx[AW-1:0] == '0) ? CW'(clr_span) : '0;
        if (32'(clr_idx) == 32'(CLR_DEPTH - 1)) begin
          state_next = bcc_pkg::S_IDLE;
        end
      end
      bcc_pkg::S_IDLE: begin
        lr_addr = PW'(first32);
        if (in_xfer) begin
          if (opcode == bcc_pkg::OP_QUERY) begin
            state_next = q_empty ? bcc_pkg::S_DONE : bcc_pkg::S_WALK;
          end else if (upd_ok) begin
            state_next = bcc_pkg::S_UPD_READ;
          end
        end
      end
      bcc_pkg::S_UPD_READ: begin
        // old letter is back; fetch its block count
        cr_addr    = blk_base | CA_W'(lr_data);
        state_next = bcc_pkg::S_UPD_DEC;
      end
      bcc_pkg::S_UPD_DEC: begin
        cw_en      = cr_data != '0;
        lw_en      = 1'b1;
        state_next = bcc_pkg::S_UPD_INC;
      end
      bcc_pkg::S_UPD_INC: begin
        // read after the decrement has landed, same entry when letters match
        cr_addr    = blk_base | CA_W'(code);
        state_next = bcc_pkg::S_UPD_WRITE;
      end
      bcc_pkg::S_UPD_WRITE: begin
        cw_en      = 1'b1;
        cw_addr    = blk_base | CA_W'(code);
        cw_data    = cr_data + CW'(1);
        state_next = bcc_pkg::S_IDLE;
      end
      bcc_pkg::S_WALK: begin
        if (walk.done) begin
          state_next = bcc_pkg::S_DONE;
        end
      end
      bcc_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = bcc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bcc_pkg::S_IDLE;
      end
    endcase
  end

  // clear pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == bcc_pkg::S_CLEAR) begin
      clr_idx <= clr_idx + CLR_W'(1);
    end
  end

  // item payload capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pos      <= PW'(first32);
      code     <= letter;
      res_zero <= q_empty;
    end
    if (state == bcc_pkg::S_UPD_READ) begin
      old_addr <= blk_base | CA_W'(lr_data);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == bcc_pkg::S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bcc_pkg::S_DONE && (!out_valid || out_ready)) begin
      count <= res_zero ? '0 : bcc_pkg::COUNT_W'(walk_total);
    end
  end

  // letter string memory
  bcc_ram #(
    .WIDTH (bcc_pkg::LETTER_W),
    .DEPTH (STRING_LENGTH)
  ) u_letters (
    .clk   (clk),
    .we    (lw_en),
    .waddr (lw_addr),
    .wdata (lw_data),
    .raddr (lr_addr),
    .rdata (lr_data)
  );

  // per-block letter count memory
  bcc_ram #(
    .WIDTH (CW),
    .DEPTH (CDEPTH)
  ) u_counts (
    .clk   (clk),
    .we    (cw_en),
    .waddr (cw_addr),
    .wdata (cw_data),
    .raddr (cr_addr),
    .rdata (cr_data)
  );

  // query range walker
  bcc_walker #(
    .STRING_LENGTH (STRING_LENGTH),
    .BLK_SIZE      (BLK_SIZE),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_walker (
    .clk          (clk),
    .rst          (rst),
    .start        (walk_start),
    .start_lo     (PW'(first32)),
    .start_hi     (PW'(hi32)),
    .start_code   (letter),
    .letter_rdata (lr_data),
    .count_rdata  (cr_data),
    .walk         (walk),
    .letter_raddr (walk_laddr),
    .count_raddr  (walk_caddr),
    .total        (walk_total)
  );

  // walker uses one memory per step
  assert property (@(posedge clk) disable iff (rst)
    !(walk.letter_rd && walk.count_rd))
    else $error("walker read both memories in one step");

  // walker finishes only while the controller waits for it
  assert property (@(posedge clk) disable iff (rst)
    walk.done |-> (state == bcc_pkg::S_WALK))
    else $error("walker done outside of a query");

  // an update transfer never produces a result
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (opcode == bcc_pkg::OP_UPDATE)) |=> !$rose(out_valid))
    else $error("result raised after an update");

  // no walker finish and no result while the memories are being cleared
  assert property (@(posedge clk) disable iff (rst)
    (state == bcc_pkg::S_CLEAR) |-> !walk.done && !out_valid)
    else $error("activity during clear pass");

endmodule

// ===== hdl/bcc_ram.sv =====
// ----------------------------------------------------------------------------
// bcc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/bcc_walker.sv =====
// ----------------------------------------------------------------------------
// bcc_walker
// Walks a query range: one memory read per cycle, a letter read for each
// position of a partial block and a count read for each whole block, and
// sums the returned data in the cycle after each read.
// ----------------------------------------------------------------------------
module bcc_walker #(
  parameter int STRING_LENGTH = 4096,
  parameter int BLK_SIZE      = 64,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [$clog2(STRING_LENGTH)-1:0]       start_lo,
  input  logic [$clog2(STRING_LENGTH)-1:0]       start_hi,
  input  logic [bcc_pkg::LETTER_W-1:0]           start_code,
  input  logic [bcc_pkg::LETTER_W-1:0]           letter_rdata,
  input  logic [$clog2(BLK_SIZE+1)-1:0]          count_rdata,
  output bcc_pkg::walk_t                         walk,
  output logic [$clog2(STRING_LENGTH)-1:0]       letter_raddr,
  output logic [$clog2(((STRING_LENGTH + BLK_SIZE - 1) / BLK_SIZE)
                       * (2 ** $clog2(ALPHABET_SIZE)))-1:0] count_raddr,
  output logic [$clog2(STRING_LENGTH+1)-1:0]     total
);

  localparam int PW   = $clog2(STRING_LENGTH);
  localparam int BW   = $clog2(BLK_SIZE);
  localparam int AW   = $clog2(ALPHABET_SIZE);
  localparam int NB   = (STRING_LENGTH + BLK_SIZE - 1) / BLK_SIZE;
  localparam int CA_W = $clog2(NB * (2 ** AW));
  localparam int TW   = $clog2(STRING_LENGTH + 1);
  localparam int EW   = $clog2(STRING_LENGTH + BLK_SIZE);

  logic                         active;
  logic [EW-1:0]                lo;
  logic [PW-1:0]                hi;
  logic [bcc_pkg::LETTER_W-1:0] code;
  logic                         pend;
  logic                         pend_count;
  logic                         more;
  logic                         use_blk;

  // next step: whole block when aligned and the block fits in the range
  always_comb begin
    more    = lo <= EW'(hi);
    use_blk = (lo[BW-1:0] == '0) && ((lo + EW'(BLK_SIZE - 1)) <= EW'(hi));
    walk.letter_rd = active && more && !use_blk;
    walk.count_rd  = active && more && use_blk;
    walk.done      = active && !more && !pend;
    letter_raddr   = lo[PW-1:0];
    count_raddr    = CA_W'((32'(lo) >> BW) << AW) | CA_W'(code);
  end

  // walk position and read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pend   <= 1'b0;
    end else if (start) begin
      active <= 1'b1;
      pend   <= 1'b0;
    end else if (active) begin
      pend <= more;
      if (walk.done) begin
        active <= 1'b0;
      end
    end
  end

  // payload: range bounds, step kind and running sum
  always_ff @(posedge clk) begin
    if (start) begin
      lo    <= EW'(start_lo);
      hi    <= start_hi;
      code  <= start_code;
      total <= '0;
    end else begin
      if (active && more) begin
        lo         <= use_blk ? lo + EW'(BLK_SIZE) : lo + EW'(1);
        pend_count <= use_blk;
      end
      if (pend) begin
        if (pend_count) begin
          total <= total + TW'(count_rdata);
        end else if (letter_rdata == code) begin
          total <= total + TW'(1);
        end
      end
    end
  end

endmodule
